// File: design/bspc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bspc_pkg: shared types and codes of the byte stream pattern carver
// register indexes, scan modes, field limits and the structs that pass
// between the scanner, the tally and the top level
// ----------------------------------------------------------------------------
package bspc_pkg;

  // scan modes
  localparam logic [1:0] MODE_KEY   = 2'd0;
  localparam logic [1:0] MODE_DIGIT = 2'd1;
  localparam logic [1:0] MODE_ALNUM = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MODE = 2'd0;
  localparam logic [1:0] REG_SEP  = 2'd1;
  localparam logic [1:0] REG_KEY  = 2'd2;
  localparam logic [1:0] REG_KLEN = 2'd3;

  // register reset values
  localparam logic [7:0] SEP_RESET  = 8'd58;
  localparam logic [3:0] KLEN_RESET = 4'd1;

  // field shape of the format modes
  localparam logic [2:0] DIGIT_LAST_FIELD = 3'd3;
  localparam logic [2:0] DIGIT_CHARS      = 3'd4;
  localparam logic [2:0] ALNUM_LAST_FIELD = 3'd5;
  localparam logic [2:0] ALNUM_CHARS      = 3'd2;

  // character bounds
  localparam logic [7:0] CHR_0 = 8'h30;
  localparam logic [7:0] CHR_9 = 8'h39;
  localparam logic [7:0] CHR_UA = 8'h41;
  localparam logic [7:0] CHR_UZ = 8'h5a;
  localparam logic [7:0] CHR_LA = 8'h61;
  localparam logic [7:0] CHR_LZ = 8'h7a;

  // outcome of one byte against the attempt
  localparam logic [1:0] FEED_TAKEN     = 2'd0;
  localparam logic [1:0] FEED_DONE_INCL = 2'd1;
  localparam logic [1:0] FEED_DONE_EXCL = 2'd2;
  localparam logic [1:0] FEED_FAIL      = 2'd3;

  // configuration seen by the scanner
  typedef struct packed {
    logic [1:0]  scan_mode;
    logic [7:0]  separator;
    logic [63:0] match_key;
    logic [3:0]  key_length;
  } cfg_t;

  // match found by the scanner for one byte
  typedef struct packed {
    logic       hit;
    logic [7:0] ctx;
    logic [4:0] len;
  } match_t;

endpackage
`default_nettype wire

// File: design/byte_stream_pattern_carver_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stream_pattern_carver_unit: byte stream pattern carver
// scans one byte per word for a literal key or a separator-joined field
// format and reports each match with its context byte tally
// ----------------------------------------------------------------------------
// throughput: one byte per cycle unless the output stalls; the count memory
//   read in the match stage and the increment-and-write into the output
//   register are the two stages that a result word passes through
// reset: synchronous; clears registers, attempt state and all tally valid bits
//   at once, so the block takes bytes in the first cycle after reset
module byte_stream_pattern_carver_unit #(
  parameter int KEY_MAX_BYTES = 8,
  parameter int COUNT_WIDTH   = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // apb configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready,
  // input stream, tdata: data_byte[7:0]
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  // output stream, tdata: context_byte[7:0], match_length[12:8],
  // context_count[44:13], zero pad[47:45]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata
);

  bspc_pkg::cfg_t   cfg;
  bspc_pkg::match_t match;
  logic             wr_en;
  logic             drop;
  logic             fire;
  logic             o_free;
  logic             m_valid;
  logic [7:0]       m_ctx;
  logic [4:0]       m_len;
  logic [31:0]      m_count;
  logic [7:0]       o_ctx;
  logic [4:0]       o_len;
  logic [31:0]      o_cnt;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign drop   = wr_en && (paddr[4:3] == bspc_pkg::REG_MODE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scan_mode  <= bspc_pkg::MODE_KEY;
      cfg.separator  <= bspc_pkg::SEP_RESET;
      cfg.match_key  <= 64'd0;
      cfg.key_length <= bspc_pkg::KLEN_RESET;
    end else if (wr_en) begin
      unique case (paddr[4:3])
        bspc_pkg::REG_MODE: cfg.scan_mode  <= pwdata[1:0];
        bspc_pkg::REG_SEP:  cfg.separator  <= pwdata[7:0];
        bspc_pkg::REG_KEY:  cfg.match_key  <= pwdata;
        bspc_pkg::REG_KLEN: cfg.key_length <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (paddr[4:3])
      bspc_pkg::REG_MODE: prdata = 64'(cfg.scan_mode);
      bspc_pkg::REG_SEP:  prdata = 64'(cfg.separator);
      bspc_pkg::REG_KEY:  prdata = cfg.match_key;
      bspc_pkg::REG_KLEN: prdata = 64'(cfg.key_length);
      default:            prdata = 64'd0;
    endcase
  end

  // handshake
  assign o_free        = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !m_valid || o_free;
  assign fire          = s_axis_tvalid && s_axis_tready;

  bspc_scan #(
    .KEY_MAX_BYTES (KEY_MAX_BYTES)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .drop      (drop),
    .fire      (fire),
    .data_byte (s_axis_tdata),
    .match     (match)
  );

  bspc_tally #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_tally (
    .clk     (clk),
    .rst     (rst),
    .load    (fire && match.hit),
    .match   (match),
    .adv     (o_free),
    .m_valid (m_valid),
    .m_ctx   (m_ctx),
    .m_len   (m_len),
    .m_count (m_count)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (o_free) begin
      m_axis_tvalid <= m_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free && m_valid) begin
      o_ctx <= m_ctx;
      o_len <= m_len;
      o_cnt <= m_count;
    end
  end

  assign m_axis_tdata = {3'b000, o_cnt, o_len, o_ctx};

endmodule
`default_nettype wire

// File: design/bspc_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bspc_scan: pattern scanner
// keeps the attempt state and decides per byte whether a match completes,
// including the retry of a failing byte as the start of a new attempt
// ----------------------------------------------------------------------------
module bspc_scan #(
  parameter int KEY_MAX_BYTES = 8
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bspc_pkg::cfg_t  cfg,
  input  wire logic            drop,
  input  wire logic            fire,
  input  wire logic [7:0]      data_byte,
  output bspc_pkg::match_t     match
);

  localparam int KPW = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
  localparam logic [3:0] KEY_MAX_L = 4'(KEY_MAX_BYTES);

  typedef struct packed {
    logic [KPW-1:0] kp;
    logic [2:0]     fi;
    logic [2:0]     cif;
    logic [4:0]     cons;
  } att_t;

  typedef struct packed {
    logic [1:0] code;
    att_t       st;
  } feed_t;

  // one byte against one attempt state
  function automatic feed_t feed(att_t s, logic [7:0] b, bspc_pkg::cfg_t c);
    feed_t      r;
    logic [3:0] len_eff;
    logic [3:0] kp1;
    logic [7:0] kb;
    logic [2:0] maxc;
    logic [2:0] lastf;
    logic       cls;
    logic       dig;
    logic [2:0] cif1;
    r.code  = bspc_pkg::FEED_FAIL;
    r.st    = s;
    dig     = (b >= bspc_pkg::CHR_0) && (b <= bspc_pkg::CHR_9);
    len_eff = (c.key_length == 4'd0) ? 4'd1 :
              ((c.key_length > KEY_MAX_L) ? KEY_MAX_L : c.key_length);
    kb      = c.match_key[{s.kp, 3'b000} +: 8];
    kp1     = 4'(s.kp) + 4'd1;
    cif1    = s.cif + 3'd1;
    if (c.scan_mode == bspc_pkg::MODE_DIGIT) begin
      maxc  = bspc_pkg::DIGIT_CHARS;
      lastf = bspc_pkg::DIGIT_LAST_FIELD;
      cls   = dig;
    end else begin
      maxc  = bspc_pkg::ALNUM_CHARS;
      lastf = bspc_pkg::ALNUM_LAST_FIELD;
      cls   = dig || ((b >= bspc_pkg::CHR_UA) && (b <= bspc_pkg::CHR_UZ)) ||
              ((b >= bspc_pkg::CHR_LA) && (b <= bspc_pkg::CHR_LZ));
    end
    case (c.scan_mode) inside
      bspc_pkg::MODE_KEY: begin
        if (b == kb) begin
          r.st.kp   = KPW'(kp1);
          r.st.cons = 5'(kp1);
          r.code    = (kp1 >= len_eff) ? bspc_pkg::FEED_DONE_INCL : bspc_pkg::FEED_TAKEN;
        end
      end
      bspc_pkg::MODE_DIGIT, bspc_pkg::MODE_ALNUM: begin
        if (cls && (s.cif < maxc)) begin
          r.st.cif  = cif1;
          r.st.cons = s.cons + 5'd1;
          r.code    = ((s.fi >= lastf) && (cif1 >= maxc)) ? bspc_pkg::FEED_DONE_INCL
                                                         : bspc_pkg::FEED_TAKEN;
        end else if (s.fi < lastf) begin
          if ((b == c.separator) && (s.cif != 3'd0)) begin
            r.st.fi   = s.fi + 3'd1;
            r.st.cif  = 3'd0;
            r.st.cons = s.cons + 5'd1;
            r.code    = bspc_pkg::FEED_TAKEN;
          end
        end else if (s.cif != 3'd0) begin
          r.code = bspc_pkg::FEED_DONE_EXCL;
        end
      end
      default: r.code = bspc_pkg::FEED_FAIL;
    endcase
    return r;
  endfunction

  att_t       att;
  att_t       att_next;
  logic [7:0] last_byte;
  logic [7:0] start_ctx;
  logic [7:0] start_ctx_next;

  feed_t      f1;
  feed_t      f2;
  logic       emit1;
  logic       emit2;
  logic       retry1;
  logic [7:0] sc1;
  att_t       st1;
  att_t       st2;

  // first pass on the live attempt, second pass on a fresh one
  always_comb begin
    f1     = feed(att, data_byte, cfg);
    f2     = feed('0, data_byte, cfg);
    sc1    = (att.cons == 5'd0) ? last_byte : start_ctx;
    emit1  = (f1.code == bspc_pkg::FEED_DONE_INCL) || (f1.code == bspc_pkg::FEED_DONE_EXCL);
    emit2  = (f2.code == bspc_pkg::FEED_DONE_INCL) || (f2.code == bspc_pkg::FEED_DONE_EXCL);
    retry1 = (f1.code == bspc_pkg::FEED_DONE_EXCL) ||
             ((f1.code == bspc_pkg::FEED_FAIL) && (att.cons != 5'd0));
    st1    = (f1.code == bspc_pkg::FEED_TAKEN) ? f1.st : '0;
    st2    = (f2.code == bspc_pkg::FEED_TAKEN) ? f2.st : '0;
    att_next       = retry1 ? st2 : st1;
    start_ctx_next = (retry1 || (att.cons == 5'd0)) ? last_byte : start_ctx;
    match.hit = emit1 || (retry1 && emit2);
    match.ctx = emit1 ? sc1 : last_byte;
    match.len = emit1 ? f1.st.cons : f2.st.cons;
  end

  // attempt state
  always_ff @(posedge clk) begin
    if (rst) begin
      att       <= '0;
      last_byte <= 8'd0;
      start_ctx <= 8'd0;
    end else if (drop) begin
      att <= '0;
    end else if (fire) begin
      att       <= att_next;
      last_byte <= data_byte;
      start_ctx <= start_ctx_next;
    end
  end

endmodule
`default_nettype wire

// File: design/bspc_tally.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bspc_tally: context byte tally
// 256-entry count memory with registered read, valid bits cleared at reset,
// one-deep write forwarding and a saturating increment on the way out
// ----------------------------------------------------------------------------
module bspc_tally #(
  parameter int COUNT_WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire bspc_pkg::match_t match,
  input  wire logic             adv,
  output logic                  m_valid,
  output logic [7:0]            m_ctx,
  output logic [4:0]            m_len,
  output logic [31:0]           m_count
);

  logic [COUNT_WIDTH-1:0] mem [256];
  logic [COUNT_WIDTH-1:0] rd_data;
  logic [255:0]           vbit;
  logic                   fwd_valid;
  logic [7:0]             fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_val;
  logic [COUNT_WIDTH-1:0] cnt_cur;
  logic [COUNT_WIDTH-1:0] cnt_next;
  logic [63:0]            cnt_wide;
  logic                   wr;

  assign wr = m_valid && adv;

  // match stage
  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (load) begin
      m_valid <= 1'b1;
    end else if (adv) begin
      m_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_ctx <= match.ctx;
      m_len <= match.len;
    end
  end

  // count memory
  always_ff @(posedge clk) begin
    if (load) begin
      rd_data <= mem[match.ctx];
    end
    if (wr) begin
      mem[m_ctx] <= cnt_next;
    end
  end

  // valid bits and last write
  always_ff @(posedge clk) begin
    if (rst) begin
      vbit      <= '0;
      fwd_valid <= 1'b0;
    end else if (wr) begin
      vbit[m_ctx] <= 1'b1;
      fwd_valid   <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      fwd_addr <= m_ctx;
      fwd_val  <= cnt_next;
    end
  end

  // current count and saturating bump
  always_comb begin
    if (fwd_valid && (fwd_addr == m_ctx)) begin
      cnt_cur = fwd_val;
    end else if (vbit[m_ctx]) begin
      cnt_cur = rd_data;
    end else begin
      cnt_cur = '0;
    end
    cnt_next = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_WIDTH'(1);
    cnt_wide = 64'(cnt_next);
    m_count  = cnt_wide[31:0];
  end

`ifndef SYNTH
  // a new match only lands when the stage is free
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_valid && !adv) |-> !load)
    else $error("match stage overrun");

  // a stalled match keeps its context
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_valid && !adv) |=> (m_valid && $stable(m_ctx) && $stable(m_len)))
    else $error("stalled match changed");

  // each write becomes the forwarded entry
  a_fwd: assert property (@(posedge clk) disable iff (rst)
    wr |=> (fwd_valid && (fwd_addr == $past(m_ctx))))
    else $error("forward entry not updated");

  // a reported count is never zero
  a_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_valid |-> (cnt_next != '0))
    else $error("zero count reported");
`endif

endmodule
`default_nettype wire
